[sv/ter_pkg.sv]
// Shared types, widths and register codes of the triangle edge rasterizer.
`default_nettype none
package ter_pkg;

  localparam int VTX_W     = 16;
  localparam int COLOR_W   = 2;
  localparam int CFG_IDX_W = 3;
  localparam int COORD_W   = 12;
  localparam int BOX_W     = 18;
  localparam int DIFF_W    = VTX_W + 1;
  localparam int AREA_W    = 2 * DIFF_W + 1;
  localparam int DX_W      = VTX_W + 2;
  localparam int DP_W      = 24;
  localparam int PROD_W    = DX_W + DP_W;
  localparam int EDGE_W    = PROD_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_A_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_C_X   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_C_Y   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR = 3'd6;

  typedef enum logic [1:0] {
    SIGN_NONE = 2'd0,
    SIGN_POS  = 2'd1,
    SIGN_NEG  = 2'd2
  } area_sign_t;

  typedef struct packed {
    logic signed [VTX_W-1:0] ax;
    logic signed [VTX_W-1:0] ay;
    logic signed [VTX_W-1:0] bx;
    logic signed [VTX_W-1:0] by;
    logic signed [VTX_W-1:0] cx;
    logic signed [VTX_W-1:0] cy;
  } vertices_t;

  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] bottom;
    area_sign_t         sign;
    logic               empty;
  } setup_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    area_sign_t         sign;
    logic               empty;
    logic               last;
  } pixel_t;

  typedef struct packed {
    logic load_pix;
    logic load_prod;
    logic load_out;
  } pipe_ctl_t;

endpackage
`default_nettype wire

[sv/ter_setup.sv]
// Configuration registers and the pipelined bounding box and area sign setup.
`default_nettype none
module ter_setup import ter_pkg::*; #(
  parameter int FRAME_WIDTH   = 256,
  parameter int FRAME_HEIGHT  = 256,
  parameter int FRACTION_BITS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VTX_W-1:0]     cfg_data,
  output vertices_t            vertices,
  output logic [COLOR_W-1:0]   fill_color,
  output setup_t               setup
);

  localparam logic signed [BOX_W-1:0] FW_S = BOX_W'(FRAME_WIDTH);
  localparam logic signed [BOX_W-1:0] FH_S = BOX_W'(FRAME_HEIGHT);

  function automatic logic signed [BOX_W-1:0] px_floor(input logic signed [VTX_W-1:0] v);
    logic signed [BOX_W-1:0] e;
    e = BOX_W'(v);
    return e >>> FRACTION_BITS;
  endfunction

  function automatic logic signed [BOX_W-1:0] px_ceil(input logic signed [VTX_W-1:0] v);
    logic signed [BOX_W-1:0] e;
    e = BOX_W'(v) + BOX_W'((1 << FRACTION_BITS) - 1);
    return e >>> FRACTION_BITS;
  endfunction

  function automatic logic signed [VTX_W-1:0] min3(input logic signed [VTX_W-1:0] a,
                                                   input logic signed [VTX_W-1:0] b,
                                                   input logic signed [VTX_W-1:0] c);
    logic signed [VTX_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [VTX_W-1:0] max3(input logic signed [VTX_W-1:0] a,
                                                   input logic signed [VTX_W-1:0] b,
                                                   input logic signed [VTX_W-1:0] c);
    logic signed [VTX_W-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  logic signed [DIFF_W-1:0]   d_bax, d_cay, d_bay, d_cax;
  logic signed [BOX_W-1:0]    fl_x, fl_y, cl_x, cl_y;
  logic signed [BOX_W-1:0]    x0, x1, y0, y1;
  logic signed [2*DIFF_W-1:0] prod_a, prod_b;
  logic signed [AREA_W-1:0]   area;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertices   <= '0;
      fill_color <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_A_X:   vertices.ax <= cfg_data;
        REG_A_Y:   vertices.ay <= cfg_data;
        REG_B_X:   vertices.bx <= cfg_data;
        REG_B_Y:   vertices.by <= cfg_data;
        REG_C_X:   vertices.cx <= cfg_data;
        REG_C_Y:   vertices.cy <= cfg_data;
        REG_COLOR: fill_color  <= cfg_data[COLOR_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    d_bax = DIFF_W'(vertices.bx) - DIFF_W'(vertices.ax);
    d_cay = DIFF_W'(vertices.cy) - DIFF_W'(vertices.ay);
    d_bay = DIFF_W'(vertices.by) - DIFF_W'(vertices.ay);
    d_cax = DIFF_W'(vertices.cx) - DIFF_W'(vertices.ax);
    fl_x  = px_floor(min3(vertices.ax, vertices.bx, vertices.cx));
    fl_y  = px_floor(min3(vertices.ay, vertices.by, vertices.cy));
    cl_x  = px_ceil(max3(vertices.ax, vertices.bx, vertices.cx));
    cl_y  = px_ceil(max3(vertices.ay, vertices.by, vertices.cy));
  end

  always_ff @(posedge clk) begin
    prod_a <= d_bax * d_cay;
    prod_b <= d_bay * d_cax;
    x0     <= (fl_x < 0) ? '0 : fl_x;
    y0     <= (fl_y < 0) ? '0 : fl_y;
    x1     <= (cl_x > FW_S) ? FW_S : cl_x;
    y1     <= (cl_y > FH_S) ? FH_S : cl_y;
  end

  assign area = AREA_W'(prod_a) - AREA_W'(prod_b);

  always_ff @(posedge clk) begin
    setup.empty  <= (area == '0) || (x0 >= x1) || (y0 >= y1);
    setup.sign   <= area[AREA_W-1] ? SIGN_NEG : SIGN_POS;
    setup.left   <= COORD_W'(x0);
    setup.right  <= COORD_W'(x1 - BOX_W'(1));
    setup.top    <= COORD_W'(y0);
    setup.bottom <= COORD_W'(y1 - BOX_W'(1));
  end

endmodule
`default_nettype wire

[sv/ter_scan.sv]
// Scan position state: walks the bounding box one pixel per beat.
`default_nettype none
module ter_scan import ter_pkg::*; #(
  parameter int FRAME_WIDTH  = 256,
  parameter int FRAME_HEIGHT = 256
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   fire,
  input  setup_t setup,
  output pixel_t pixel
);

  localparam int XW = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
  localparam int YW = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;

  logic [XW-1:0] scan_x, scan_x_next, box_left, box_left_next, box_right, box_right_next;
  logic [YW-1:0] scan_y, scan_y_next, box_bottom, box_bottom_next;
  area_sign_t    area_sign, area_sign_next;
  logic          scanning, scanning_next;

  logic [XW-1:0] cur_x, cur_left, cur_right;
  logic [YW-1:0] cur_y, cur_bottom;
  area_sign_t    cur_sign;
  logic          empty_scan, end_row, end_box;

  always_comb begin
    cur_x      = scanning ? scan_x : setup.left[XW-1:0];
    cur_y      = scanning ? scan_y : setup.top[YW-1:0];
    cur_left   = scanning ? box_left : setup.left[XW-1:0];
    cur_right  = scanning ? box_right : setup.right[XW-1:0];
    cur_bottom = scanning ? box_bottom : setup.bottom[YW-1:0];
    cur_sign   = scanning ? area_sign : setup.sign;
    empty_scan = !scanning && setup.empty;
    end_row    = cur_x >= cur_right;
    end_box    = end_row && (cur_y >= cur_bottom);

    scan_x_next     = scan_x;
    scan_y_next     = scan_y;
    box_left_next   = box_left;
    box_right_next  = box_right;
    box_bottom_next = box_bottom;
    area_sign_next  = area_sign;
    scanning_next   = scanning;

    if (fire && !empty_scan) begin
      box_left_next   = cur_left;
      box_right_next  = cur_right;
      box_bottom_next = cur_bottom;
      area_sign_next  = cur_sign;
      if (end_row) begin
        if (end_box) begin
          scanning_next = 1'b0;
        end else begin
          scan_x_next   = cur_left;
          scan_y_next   = cur_y + 1'b1;
          scanning_next = 1'b1;
        end
      end else begin
        scan_x_next   = cur_x + 1'b1;
        scan_y_next   = cur_y;
        scanning_next = 1'b1;
      end
    end

    if (empty_scan) begin
      pixel.x     = '0;
      pixel.y     = '0;
      pixel.sign  = SIGN_NONE;
      pixel.empty = 1'b1;
      pixel.last  = 1'b1;
    end else begin
      pixel.x     = COORD_W'(cur_x);
      pixel.y     = COORD_W'(cur_y);
      pixel.sign  = cur_sign;
      pixel.empty = 1'b0;
      pixel.last  = end_box;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_x     <= '0;
      scan_y     <= '0;
      box_left   <= '0;
      box_right  <= '0;
      box_bottom <= '0;
      area_sign  <= SIGN_NONE;
      scanning   <= 1'b0;
    end else begin
      scan_x     <= scan_x_next;
      scan_y     <= scan_y_next;
      box_left   <= box_left_next;
      box_right  <= box_right_next;
      box_bottom <= box_bottom_next;
      area_sign  <= area_sign_next;
      scanning   <= scanning_next;
    end
  end

endmodule
`default_nettype wire

[sv/ter_edge.sv]
// Edge function products, coverage test and the result register.
`default_nettype none
module ter_edge import ter_pkg::*; #(
  parameter int FRACTION_BITS = 4
) (
  input  logic               clk,
  input  pipe_ctl_t          ctl,
  input  pixel_t             pixel_in,
  input  vertices_t          vertices,
  input  logic [COLOR_W-1:0] fill_color,
  output logic [7:0]         pixel_x,
  output logic [7:0]         pixel_y,
  output logic               covered,
  output logic [COLOR_W-1:0] pixel_color,
  output logic               empty_res,
  output logic               last
);

  pixel_t pix3, pix4;

  logic signed [DP_W-1:0]   ux [3];
  logic signed [DP_W-1:0]   uy [3];
  logic signed [DP_W-1:0]   vx [3];
  logic signed [DP_W-1:0]   vy [3];
  logic signed [DP_W-1:0]   pcx, pcy;
  logic signed [DX_W-1:0]   dx [3];
  logic signed [DX_W-1:0]   dy [3];
  logic signed [DP_W-1:0]   qx [3];
  logic signed [DP_W-1:0]   qy [3];
  logic signed [PROD_W-1:0] lhs [3];
  logic signed [PROD_W-1:0] rhs [3];
  logic signed [PROD_W-1:0] lhs_q [3];
  logic signed [PROD_W-1:0] rhs_q [3];
  logic signed [EDGE_W-1:0] e [3];
  logic [2:0]               ok;
  logic                     cov;

  always_ff @(posedge clk) begin
    if (ctl.load_pix) begin
      pix3 <= pixel_in;
    end
  end

  always_comb begin
    ux[0] = DP_W'(vertices.ax) <<< 1;
    uy[0] = DP_W'(vertices.ay) <<< 1;
    ux[1] = DP_W'(vertices.bx) <<< 1;
    uy[1] = DP_W'(vertices.by) <<< 1;
    ux[2] = DP_W'(vertices.cx) <<< 1;
    uy[2] = DP_W'(vertices.cy) <<< 1;
    vx[0] = ux[1];
    vy[0] = uy[1];
    vx[1] = ux[2];
    vy[1] = uy[2];
    vx[2] = ux[0];
    vy[2] = uy[0];
    pcx   = $signed(DP_W'({pix3.x, 1'b1}) << FRACTION_BITS);
    pcy   = $signed(DP_W'({pix3.y, 1'b1}) << FRACTION_BITS);
    for (int k = 0; k < 3; k++) begin
      dx[k]  = DX_W'(vx[k] - ux[k]);
      dy[k]  = DX_W'(vy[k] - uy[k]);
      qx[k]  = pcx - ux[k];
      qy[k]  = pcy - uy[k];
      lhs[k] = dx[k] * qy[k];
      rhs[k] = dy[k] * qx[k];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      pix4 <= pix3;
      for (int k = 0; k < 3; k++) begin
        lhs_q[k] <= lhs[k];
        rhs_q[k] <= rhs[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e[k]  = EDGE_W'(lhs_q[k]) - EDGE_W'(rhs_q[k]);
      ok[k] = (e[k] == '0) ||
              (e[k][EDGE_W-1] ? (pix4.sign == SIGN_NEG) : (pix4.sign == SIGN_POS));
    end
    cov = !pix4.empty && (&ok);
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      pixel_x     <= pix4.x[7:0];
      pixel_y     <= pix4.y[7:0];
      covered     <= cov;
      pixel_color <= cov ? fill_color : '0;
      empty_res   <= pix4.empty;
      last        <= pix4.last;
    end
  end

endmodule
`default_nettype wire

[sv/triangle_edge_rasterizer_unit.sv]
// Top level of the triangle edge rasterizer: handshake pipeline around setup, scan and edge test.
`default_nettype none
// Each input beat with tick set yields one result beat: the next pixel of the triangle's
// clamped bounding box, scanned row by row, or a single empty result for a zero-area triangle
// or an empty box. A beat with tick clear is taken and gives nothing. Results stream at one
// per clock while out_stall is clear; a result passes from its beat through two pass stages,
// the scan counter stage, the edge multiply stage, the coverage stage and the output register.
// The box and area sign are recomputed from the vertex registers through the product and
// clamp registers and the setup register, and are latched when a scan starts; the edge tests
// and color use the live registers. Write configuration only while no result is outstanding.
module triangle_edge_rasterizer_unit import ter_pkg::*; #(
  parameter int FRAME_WIDTH   = 256,
  parameter int FRAME_HEIGHT  = 256,
  parameter int FRACTION_BITS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 tick,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VTX_W-1:0]     cfg_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           pixel_x,
  output logic [7:0]           pixel_y,
  output logic                 covered,
  output logic [COLOR_W-1:0]   pixel_color,
  output logic                 empty_res,
  output logic                 last
);

  vertices_t          vertices;
  logic [COLOR_W-1:0] fill_color;
  setup_t             setup;
  pixel_t             pixel;
  pipe_ctl_t          ctl;
  logic [4:0]         stage_valid;
  logic [5:0]         ready;
  logic               accept, fire;

  always_comb begin
    ready[5] = !out_valid || !out_stall;
    for (int i = 4; i >= 0; i--) begin
      ready[i] = !stage_valid[i] || ready[i+1];
    end
  end

  assign in_stall      = !ready[0];
  assign accept        = in_valid && !in_stall;
  assign fire          = stage_valid[2] && ready[3];
  assign ctl.load_pix  = ready[3];
  assign ctl.load_prod = ready[4];
  assign ctl.load_out  = ready[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (ready[0]) begin
        stage_valid[0] <= accept && tick;
      end
      for (int i = 1; i < 5; i++) begin
        if (ready[i]) begin
          stage_valid[i] <= stage_valid[i-1];
        end
      end
      if (ready[5]) begin
        out_valid <= stage_valid[4];
      end
    end
  end

  ter_setup #(
    .FRAME_WIDTH   (FRAME_WIDTH),
    .FRAME_HEIGHT  (FRAME_HEIGHT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_setup (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .vertices   (vertices),
    .fill_color (fill_color),
    .setup      (setup)
  );

  ter_scan #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_scan (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .setup (setup),
    .pixel (pixel)
  );

  ter_edge #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_edge (
    .clk         (clk),
    .ctl         (ctl),
    .pixel_in    (pixel),
    .vertices    (vertices),
    .fill_color  (fill_color),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .covered     (covered),
    .pixel_color (pixel_color),
    .empty_res   (empty_res),
    .last        (last)
  );

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> ((&stage_valid) && out_valid && out_stall))
    else $error("input stalled while the pipeline has a free stage");

  a_empty_beat_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && empty_res) |-> (last && !covered && (pixel_color == '0) &&
                                  (pixel_x == '0) && (pixel_y == '0)))
    else $error("empty scan result with pixel data");

  a_reset_flush: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule
`default_nettype wire
